/* hdl/cbg_pkg.sv */
`timescale 1ns / 1ps

package cbg_pkg;

    localparam int MAX_LEN  = 64;
    localparam int FILL_MAX = 1000;

    localparam int COORD_W = 8;
    localparam int LEN_W   = 7;
    localparam int FILL_W  = 10;
    localparam int CELL_W  = 4;
    localparam int CODE_W  = 8;
    localparam int IDX_W   = 2;
    localparam int TOTAL_W = 10;

    // Lit pixels are ((2 * len * cell + 1) * fill) / 2000. The division is a
    // shift by four followed by a reciprocal multiplication for 125.
    localparam int A_W         = LEN_W + CELL_W + 1;
    localparam int X_W         = A_W + FILL_W;
    localparam int DIV_SHIFT   = 4;
    localparam int Y_W         = X_W - DIV_SHIFT;
    localparam int RECIP_W     = 18;
    localparam int RECIP_SHIFT = 24;
    localparam logic [RECIP_W-1:0] RECIP = RECIP_W'(134218);
    localparam int Q_W         = Y_W + RECIP_W;

    typedef enum logic [IDX_W-1:0] {
        REG_CELL_WIDTH  = 2'd0,
        REG_CELL_HEIGHT = 2'd1,
        REG_CHAR_OFFSET = 2'd2,
        REG_SEAMLESS    = 2'd3
    } cfg_reg_t;

    typedef struct packed {
        logic [CELL_W-1:0] cell_width;
        logic [CELL_W-1:0] cell_height;
        logic [CODE_W-1:0] char_offset;
        logic              seamless_mode;
    } cfg_t;

    typedef struct packed {
        logic [COORD_W-1:0] col;
        logic [COORD_W-1:0] row;
        logic [LEN_W-1:0]   len;
        logic [CELL_W-1:0]  cell_px;
        logic               vert;
        logic [TOTAL_W-1:0] total;
    } cmd_t;

endpackage

/* hdl/char_lcd_bar_graph_cells_unit.sv */
// The front holds one request at a time: full stays high through its three multiply stages
// and until the queue takes the result. A two-entry queue sits between the two parts.
// The back writes one cell per cycle while the output is popped. It loads each request
// in its idle state, and a request that writes no cell still passes through its run state.
// Reset empties the queue and restores the registers to width 5, height 8, offset 0.
`timescale 1ns / 1ps

module char_lcd_bar_graph_cells_unit
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cfg_we,
    input  logic [cbg_pkg::IDX_W-1:0]    cfg_addr,
    input  logic [cbg_pkg::CODE_W-1:0]   cfg_wdata,
    input  logic                         push,
    output logic                         full,
    input  logic [cbg_pkg::COORD_W-1:0]  start_col,
    input  logic [cbg_pkg::COORD_W-1:0]  start_row,
    input  logic [cbg_pkg::LEN_W-1:0]    length_cells,
    input  logic [cbg_pkg::FILL_W-1:0]   fill_promille,
    input  logic                         vertical,
    output logic                         empty,
    input  logic                         pop,
    output logic [cbg_pkg::COORD_W-1:0]  cell_col,
    output logic [cbg_pkg::COORD_W-1:0]  cell_row,
    output logic                         cell_kind,
    output logic [cbg_pkg::CODE_W-1:0]   char_code,
    output logic                         last_cell
);

    import cbg_pkg::*;

    cfg_t  cfg_reg, cfg_next;
    logic  front_valid;
    cmd_t  front_cmd;
    logic  fifo_ready;
    logic  fifo_valid;
    cmd_t  fifo_cmd;
    logic  back_pop;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            case (cfg_reg_t'(cfg_addr))
                REG_CELL_WIDTH:  cfg_next.cell_width    = cfg_wdata[CELL_W-1:0];
                REG_CELL_HEIGHT: cfg_next.cell_height   = cfg_wdata[CELL_W-1:0];
                REG_CHAR_OFFSET: cfg_next.char_offset   = cfg_wdata;
                REG_SEAMLESS:    cfg_next.seamless_mode = cfg_wdata[0];
                default:         cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.cell_width    <= CELL_W'(5);
            cfg_reg.cell_height   <= CELL_W'(8);
            cfg_reg.char_offset   <= '0;
            cfg_reg.seamless_mode <= 1'b0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    cbg_front u_front
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg           (cfg_reg),
        .push          (push),
        .full          (full),
        .start_col     (start_col),
        .start_row     (start_row),
        .length_cells  (length_cells),
        .fill_promille (fill_promille),
        .vertical      (vertical),
        .cmd_valid     (front_valid),
        .cmd_ready     (fifo_ready),
        .cmd           (front_cmd)
    );

    cbg_cmd_fifo u_fifo
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (front_valid),
        .wr_data  (front_cmd),
        .wr_ready (fifo_ready),
        .rd_en    (back_pop),
        .rd_data  (fifo_cmd),
        .rd_valid (fifo_valid)
    );

    cbg_back u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .cmd_valid (fifo_valid),
        .cmd       (fifo_cmd),
        .cmd_pop   (back_pop),
        .empty     (empty),
        .pop       (pop),
        .cell_col  (cell_col),
        .cell_row  (cell_row),
        .cell_kind (cell_kind),
        .char_code (char_code),
        .last_cell (last_cell)
    );

endmodule

/* hdl/cbg_front.sv */
`timescale 1ns / 1ps

module cbg_front
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  cbg_pkg::cfg_t                cfg,
    input  logic                         push,
    output logic                         full,
    input  logic [cbg_pkg::COORD_W-1:0]  start_col,
    input  logic [cbg_pkg::COORD_W-1:0]  start_row,
    input  logic [cbg_pkg::LEN_W-1:0]    length_cells,
    input  logic [cbg_pkg::FILL_W-1:0]   fill_promille,
    input  logic                         vertical,
    output logic                         cmd_valid,
    input  logic                         cmd_ready,
    output cbg_pkg::cmd_t                cmd
);

    import cbg_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_MUL1,
        S_MUL2,
        S_DIV,
        S_PUSH
    } state_t;

    state_t              state_reg, state_next;
    cmd_t                cmd_reg, cmd_next;
    logic [FILL_W-1:0]   fill_reg, fill_next;
    logic [A_W-1:0]      a_reg, a_next;
    logic [X_W-1:0]      x_reg, x_next;
    logic [Q_W-1:0]      q_reg, q_next;
    logic [A_W-2:0]      len_cell;

    assign len_cell = (A_W-1)'(cmd_reg.len) * (A_W-1)'(cmd_reg.cell_px);

    always_comb
    begin
        state_next = state_reg;
        cmd_next   = cmd_reg;
        fill_next  = fill_reg;
        a_next     = a_reg;
        x_next     = x_reg;
        q_next     = q_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (push)
                begin
                    cmd_next.col     = start_col;
                    cmd_next.row     = start_row;
                    cmd_next.len     = (length_cells > LEN_W'(MAX_LEN)) ?
                                       LEN_W'(MAX_LEN) : length_cells;
                    cmd_next.cell_px = vertical ? cfg.cell_height : cfg.cell_width;
                    cmd_next.vert    = vertical;
                    cmd_next.total   = '0;
                    fill_next        = (fill_promille > FILL_W'(FILL_MAX)) ?
                                       FILL_W'(FILL_MAX) : fill_promille;
                    state_next       = S_MUL1;
                end
            end
            S_MUL1:
            begin
                a_next     = {len_cell, 1'b1};
                state_next = S_MUL2;
            end
            S_MUL2:
            begin
                x_next     = X_W'(a_reg) * X_W'(fill_reg);
                state_next = S_DIV;
            end
            S_DIV:
            begin
                q_next     = Q_W'(x_reg[X_W-1:DIV_SHIFT]) * Q_W'(RECIP);
                state_next = S_PUSH;
            end
            S_PUSH:
            begin
                if (cmd_ready)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cmd_reg   <= '0;
            fill_reg  <= '0;
            a_reg     <= '0;
            x_reg     <= '0;
            q_reg     <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cmd_reg   <= cmd_next;
            fill_reg  <= fill_next;
            a_reg     <= a_next;
            x_reg     <= x_next;
            q_reg     <= q_next;
        end
    end

    always_comb
    begin
        cmd       = cmd_reg;
        cmd.total = q_reg[RECIP_SHIFT +: TOTAL_W];
    end

    assign full      = (state_reg != S_IDLE);
    assign cmd_valid = (state_reg == S_PUSH);

endmodule

/* hdl/cbg_cmd_fifo.sv */
`timescale 1ns / 1ps

module cbg_cmd_fifo
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          wr_en,
    input  cbg_pkg::cmd_t wr_data,
    output logic          wr_ready,
    input  logic          rd_en,
    output cbg_pkg::cmd_t rd_data,
    output logic          rd_valid
);

    import cbg_pkg::*;

    cmd_t        mem_reg [2];
    logic        wr_ptr_reg, wr_ptr_next;
    logic        rd_ptr_reg, rd_ptr_next;
    logic [1:0]  count_reg, count_next;
    logic        do_wr, do_rd;

    assign wr_ready = (count_reg != 2'd2);
    assign rd_valid = (count_reg != 2'd0);
    assign do_wr    = wr_en && wr_ready;
    assign do_rd    = rd_en && rd_valid;
    assign rd_data  = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = do_wr ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = do_rd ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg;
        if (do_wr && !do_rd)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (do_rd && !do_wr)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

/* hdl/cbg_back.sv */
`timescale 1ns / 1ps

module cbg_back
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  cbg_pkg::cfg_t                cfg,
    input  logic                         cmd_valid,
    input  cbg_pkg::cmd_t                cmd,
    output logic                         cmd_pop,
    output logic                         empty,
    input  logic                         pop,
    output logic [cbg_pkg::COORD_W-1:0]  cell_col,
    output logic [cbg_pkg::COORD_W-1:0]  cell_row,
    output logic                         cell_kind,
    output logic [cbg_pkg::CODE_W-1:0]   char_code,
    output logic                         last_cell
);

    import cbg_pkg::*;

    typedef enum logic {
        S_IDLE,
        S_RUN
    } state_t;

    state_t              state_reg, state_next;
    cmd_t                cur_reg, cur_next;
    logic [TOTAL_W-1:0]  rem_reg, rem_next;
    logic [LEN_W-1:0]    pos_reg, pos_next;
    logic                out_valid_reg, out_valid_next;
    logic [COORD_W-1:0]  col_reg, col_next;
    logic [COORD_W-1:0]  row_reg, row_next;
    logic                kind_reg, kind_next;
    logic [CODE_W-1:0]   code_reg, code_next;
    logic                last_reg, last_next;

    logic                advance;
    logic                full_cell;
    logic [TOTAL_W-1:0]  rem_after;
    logic [LEN_W-1:0]    pos_after;
    logic                seamless_cell;

    assign advance       = !out_valid_reg || pop;
    assign full_cell     = (rem_reg >= TOTAL_W'(cur_reg.cell_px));
    assign rem_after     = rem_reg - TOTAL_W'(cur_reg.cell_px);
    assign pos_after     = pos_reg + LEN_W'(1);
    assign seamless_cell = !cur_reg.vert && cfg.seamless_mode;
    assign cmd_pop       = (state_reg == S_IDLE) && cmd_valid;

    always_comb
    begin
        state_next     = state_reg;
        cur_next       = cur_reg;
        rem_next       = rem_reg;
        pos_next       = pos_reg;
        out_valid_next = out_valid_reg;
        col_next       = col_reg;
        row_next       = row_reg;
        kind_next      = kind_reg;
        code_next      = code_reg;
        last_next      = last_reg;
        if (advance)
        begin
            out_valid_next = 1'b0;
        end
        case (state_reg)
            S_IDLE:
            begin
                if (cmd_valid)
                begin
                    cur_next   = cmd;
                    rem_next   = cmd.total;
                    pos_next   = '0;
                    state_next = S_RUN;
                end
            end
            S_RUN:
            begin
                if (advance)
                begin
                    if ((rem_reg == '0) || (pos_reg == cur_reg.len))
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        out_valid_next = 1'b1;
                        col_next = cur_reg.vert ? cur_reg.col :
                                   cur_reg.col + COORD_W'(pos_reg);
                        row_next = cur_reg.vert ? cur_reg.row - COORD_W'(pos_reg) :
                                   cur_reg.row;
                        if (full_cell)
                        begin
                            kind_next  = seamless_cell;
                            code_next  = seamless_cell ?
                                         CODE_W'(cur_reg.cell_px) + cfg.char_offset : '0;
                            last_next  = (pos_after == cur_reg.len) || (rem_after == '0);
                            rem_next   = rem_after;
                            pos_next   = pos_after;
                            state_next = last_next ? S_IDLE : S_RUN;
                        end
                        else
                        begin
                            kind_next  = 1'b1;
                            code_next  = rem_reg[CODE_W-1:0] + cfg.char_offset;
                            last_next  = 1'b1;
                            state_next = S_IDLE;
                        end
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cur_reg       <= '0;
            rem_reg       <= '0;
            pos_reg       <= '0;
            out_valid_reg <= 1'b0;
            col_reg       <= '0;
            row_reg       <= '0;
            kind_reg      <= 1'b0;
            code_reg      <= '0;
            last_reg      <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cur_reg       <= cur_next;
            rem_reg       <= rem_next;
            pos_reg       <= pos_next;
            out_valid_reg <= out_valid_next;
            col_reg       <= col_next;
            row_reg       <= row_next;
            kind_reg      <= kind_next;
            code_reg      <= code_next;
            last_reg      <= last_next;
        end
    end

    assign empty     = !out_valid_reg;
    assign cell_col  = col_reg;
    assign cell_row  = row_reg;
    assign cell_kind = kind_reg;
    assign char_code = code_reg;
    assign last_cell = last_reg;

endmodule

/* sim/char_lcd_bar_graph_cells_unit_tb.sv */
`timescale 1ns / 1ps

module char_lcd_bar_graph_cells_unit_tb;
    import cbg_pkg::*;

    typedef struct {
        logic [COORD_W-1:0] col;
        logic [COORD_W-1:0] row;
        logic [LEN_W-1:0]   len;
        logic [FILL_W-1:0]  fill;
        logic               vert;
    } bar_req_t;

    typedef struct {
        logic [COORD_W-1:0] col;
        logic [COORD_W-1:0] row;
        logic               kind;
        logic [CODE_W-1:0]  code;
        logic               last;
    } cell_wr_t;

    class bar_scoreboard;
        logic [CELL_W-1:0] width_px;
        logic [CELL_W-1:0] height_px;
        logic [CODE_W-1:0] code_base;
        logic              seamless;
        cell_wr_t          pending_cells[$];
        int                errors;
        int                bars_taken;
        int                bars_blank;
        int                cells_checked;

        function new();
            width_px      = 4'd5;
            height_px     = 4'd8;
            code_base     = '0;
            seamless      = 1'b0;
            errors        = 0;
            bars_taken    = 0;
            bars_blank    = 0;
            cells_checked = 0;
        endfunction

        function void set_reg(cfg_reg_t idx, logic [CODE_W-1:0] val);
            case (idx)
                REG_CELL_WIDTH:  width_px  = val[CELL_W-1:0];
                REG_CELL_HEIGHT: height_px = val[CELL_W-1:0];
                REG_CHAR_OFFSET: code_base = val;
                REG_SEAMLESS:    seamless  = val[0];
                default:         ;
            endcase
        endfunction

        function void note_request(bar_req_t req);
            int       size_px;
            int       n_cells;
            int       fill_pm;
            int       lit;
            int       used;
            int       pixels;
            int       count;
            cell_wr_t wr;
            size_px = req.vert ? int'(height_px) : int'(width_px);
            n_cells = (req.len > MAX_LEN) ? MAX_LEN : int'(req.len);
            fill_pm = (req.fill > FILL_MAX) ? FILL_MAX : int'(req.fill);
            lit     = ((2 * n_cells * size_px + 1) * fill_pm) / 2000;
            count   = 0;
            bars_taken++;
            for (int pos = 0; pos < n_cells; pos++)
            begin
                used = size_px * pos;
                if (lit <= used)
                    break;
                pixels  = lit - used;
                wr.col  = req.vert ? req.col : req.col + COORD_W'(pos);
                wr.row  = req.vert ? req.row - COORD_W'(pos) : req.row;
                wr.last = 1'b0;
                if (pixels >= size_px)
                begin
                    if (!req.vert && seamless)
                    begin
                        wr.kind = 1'b1;
                        wr.code = CODE_W'(size_px) + code_base;
                    end
                    else
                    begin
                        wr.kind = 1'b0;
                        wr.code = '0;
                    end
                end
                else
                begin
                    wr.kind = 1'b1;
                    wr.code = CODE_W'(pixels) + code_base;
                end
                pending_cells.push_back(wr);
                count++;
                if (pixels < size_px)
                    break;
            end
            if (count == 0)
                bars_blank++;
            else
                pending_cells[pending_cells.size() - 1].last = 1'b1;
        endfunction

        task flag_mismatch(string msg);
            if (errors < 40)
                $display("%0t ns: %s", $time, msg);
            errors++;
        endtask

        task check_cell(cell_wr_t got);
            cell_wr_t want;
            if (pending_cells.size() == 0)
            begin
                flag_mismatch($sformatf("unexpected cell write at col %0d row %0d",
                                        got.col, got.row));
                return;
            end
            want = pending_cells.pop_front();
            cells_checked++;
            if (got.col !== want.col || got.row !== want.row || got.kind !== want.kind ||
                got.code !== want.code || got.last !== want.last)
                flag_mismatch($sformatf(
                    "cell write col/row/kind/code/last got %0d/%0d/%0d/%0d/%0d want %0d/%0d/%0d/%0d/%0d",
                    got.col, got.row, got.kind, got.code, got.last,
                    want.col, want.row, want.kind, want.code, want.last));
        endtask
    endclass

    logic               clk           = 1'b0;
    logic               rst_n         = 1'b0;
    logic               cfg_we        = 1'b0;
    cfg_reg_t           cfg_addr      = REG_CELL_WIDTH;
    logic [CODE_W-1:0]  cfg_wdata     = '0;
    logic               push          = 1'b0;
    logic               full;
    logic [COORD_W-1:0] start_col     = '0;
    logic [COORD_W-1:0] start_row     = '0;
    logic [LEN_W-1:0]   length_cells  = '0;
    logic [FILL_W-1:0]  fill_promille = '0;
    logic               vertical      = 1'b0;
    logic               empty;
    logic               pop           = 1'b0;
    logic [COORD_W-1:0] cell_col;
    logic [COORD_W-1:0] cell_row;
    logic               cell_kind;
    logic [CODE_W-1:0]  char_code;
    logic               last_cell;

    logic               no_idle       = 1'b0;
    int                 settings_written = 0;
    bar_scoreboard      book;

    char_lcd_bar_graph_cells_unit dut (.*);

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (no_idle || r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic logic [CELL_W-1:0] pick_cell_px();
        if ($urandom_range(0, 9) < 8)
            return CELL_W'($urandom_range(1, 8));
        return CELL_W'($urandom_range(0, 15));
    endfunction

    task automatic wait_drained(input int settle);
        while (book.pending_cells.size() != 0)
            @(posedge clk);
        repeat (settle) @(posedge clk);
    endtask

    task automatic send_bar(input logic [COORD_W-1:0] col, input logic [COORD_W-1:0] row,
                            input logic [LEN_W-1:0] len, input logic [FILL_W-1:0] fill,
                            input logic vert);
        bar_req_t req;
        int       gap;
        req.col  = col;
        req.row  = row;
        req.len  = len;
        req.fill = fill;
        req.vert = vert;
        push          <= 1'b1;
        start_col     <= col;
        start_row     <= row;
        length_cells  <= len;
        fill_promille <= fill;
        vertical      <= vert;
        do
            @(posedge clk);
        while (full);
        book.note_request(req);
        gap = pick_gap();
        if (gap > 0)
        begin
            push <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // A request that lights no pixel leaves nothing to wait for, so the block is
    // given time to finish it before the registers change.
    task automatic apply_config(input logic [CELL_W-1:0] width_px,
                                input logic [CELL_W-1:0] height_px,
                                input logic [CODE_W-1:0] offset, input logic seamless);
        cfg_reg_t          regs[4];
        logic [CODE_W-1:0] vals[4];
        regs = '{REG_CELL_WIDTH, REG_CELL_HEIGHT, REG_CHAR_OFFSET, REG_SEAMLESS};
        vals = '{CODE_W'(width_px), CODE_W'(height_px), offset, CODE_W'(seamless)};
        wait_drained(64);
        for (int i = 0; i < 4; i++)
        begin
            cfg_we    <= 1'b1;
            cfg_addr  <= regs[i];
            cfg_wdata <= vals[i];
            @(posedge clk);
            book.set_reg(regs[i], vals[i]);
        end
        cfg_we <= 1'b0;
        settings_written++;
    endtask

    initial
    begin : result_sink
        cell_wr_t got;
        int       hold;
        hold = 0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (pop && !empty)
            begin
                got.col  = cell_col;
                got.row  = cell_row;
                got.kind = cell_kind;
                got.code = char_code;
                got.last = last_cell;
                book.check_cell(got);
            end
            if (hold > 0)
            begin
                pop <= 1'b0;
                hold--;
            end
            else
            begin
                pop <= 1'b1;
                if (!no_idle && $urandom_range(0, 2) == 0)
                    hold = pick_gap();
            end
        end
    end

    initial
    begin : stimulus
        int                 r;
        logic [LEN_W-1:0]   len;
        logic [FILL_W-1:0]  fill;
        book = new();
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_bar(8'd0, 8'd0, 7'd0, 10'd1000, 1'b0);
        send_bar(8'd10, 8'd1, 7'd12, 10'd0, 1'b0);
        send_bar(8'd250, 8'd2, 7'd64, 10'd1000, 1'b0);
        send_bar(8'd3, 8'd5, 7'd127, 10'd1000, 1'b1);
        send_bar(8'd40, 8'd3, 7'd3, 10'd1023, 1'b0);
        send_bar(8'd1, 8'd1, 7'd5, 10'd500, 1'b0);
        send_bar(8'd2, 8'd2, 7'd1, 10'd1, 1'b0);
        send_bar(8'd255, 8'd255, 7'd1, 10'd999, 1'b1);
        send_bar(8'd7, 8'd1, 7'd4, 10'd550, 1'b1);
        push <= 1'b0;

        apply_config(4'd8, 4'd1, 8'd255, 1'b1);
        send_bar(8'd0, 8'd9, 7'd6, 10'd750, 1'b0);
        send_bar(8'd200, 8'd0, 7'd70, 10'd1000, 1'b0);
        send_bar(8'd9, 8'd0, 7'd8, 10'd600, 1'b1);
        send_bar(8'd128, 8'd128, 7'd64, 10'd2, 1'b0);
        push <= 1'b0;

        apply_config(4'd0, 4'd15, 8'd128, 1'b1);
        send_bar(8'd5, 8'd5, 7'd10, 10'd1000, 1'b0);
        send_bar(8'd17, 8'd0, 7'd64, 10'd1000, 1'b1);
        send_bar(8'd33, 8'd44, 7'd3, 10'd400, 1'b1);
        push <= 1'b0;

        apply_config(4'd1, 4'd0, 8'd0, 1'b0);
        send_bar(8'd0, 8'd7, 7'd64, 10'd1000, 1'b0);
        send_bar(8'd6, 8'd6, 7'd5, 10'd1000, 1'b1);
        send_bar(8'd85, 8'd170, 7'd1, 10'd700, 1'b0);
        push <= 1'b0;

        for (int ph = 0; ph < 7; ph++)
        begin
            apply_config(pick_cell_px(), pick_cell_px(), CODE_W'($urandom_range(0, 255)),
                         1'($urandom_range(0, 1)));
            no_idle <= (ph == 3);
            for (int n = 0; n < 40; n++)
            begin
                r = $urandom_range(0, 99);
                if (r < 70)
                    len = LEN_W'($urandom_range(0, 16));
                else if (r < 92)
                    len = LEN_W'($urandom_range(17, 64));
                else
                    len = LEN_W'($urandom_range(65, 127));
                r = $urandom_range(0, 99);
                if (r < 10)
                    fill = '0;
                else if (r < 20)
                    fill = 10'd1000;
                else if (r < 30)
                    fill = FILL_W'($urandom_range(1001, 1023));
                else
                    fill = FILL_W'($urandom_range(0, 1000));
                send_bar(COORD_W'($urandom_range(0, 255)), COORD_W'($urandom_range(0, 255)),
                         len, fill, 1'($urandom_range(0, 1)));
                if ($urandom_range(0, 29) == 0)
                begin
                    push <= 1'b0;
                    wait_drained(1);
                end
            end
            push <= 1'b0;
        end
        no_idle <= 1'b0;
        wait_drained(64);

        $display("Covered %0d bar requests (%0d with no cell write) and %0d cell writes.",
                 book.bars_taken, book.bars_blank, book.cells_checked);
        $display("Register sets applied: %0d, including zero and oversized cells.",
                 settings_written);
        if (book.errors == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

    initial
    begin : watchdog
        #50ms;
        $display("CHECK FAILED");
        $finish;
    end

endmodule

/* sim.f */
hdl/cbg_pkg.sv
hdl/cbg_front.sv
hdl/cbg_cmd_fifo.sv
hdl/cbg_back.sv
hdl/char_lcd_bar_graph_cells_unit.sv
sim/char_lcd_bar_graph_cells_unit_tb.sv
